// ===== rtl/mdst_pkg.sv =====
package mdst_pkg;

	// Drive table size and derived widths
	localparam int DRIVES = 8;
	localparam int DRV_W  = (DRIVES > 1) ? $clog2(DRIVES) : 1;

	// Drives that show up in the packed output word
	localparam int OUT_DRIVES = (DRIVES < 8) ? DRIVES : 8;

	// Field widths
	localparam int OP_W      = 3;
	localparam int ADDR_W    = 4;
	localparam int NOTE_W    = 7;
	localparam int PER_W     = 16;
	localparam int ACC_W     = 17;
	localparam int POS_W     = 8;
	localparam int INC_W     = 12;
	localparam int OUT_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// Operation codes
	localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
	localparam logic [OP_W-1:0] OP_NOTE_ON    = 3'd1;
	localparam logic [OP_W-1:0] OP_NOTE_OFF   = 3'd2;
	localparam logic [OP_W-1:0] OP_SET_PERIOD = 3'd3;
	localparam logic [OP_W-1:0] OP_HOME       = 3'd4;
	localparam logic [OP_W-1:0] OP_HALT       = 3'd5;
	localparam logic [OP_W-1:0] OP_SET_MOVE   = 3'd6;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEP_INC      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POS       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POS_STILL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_POS_STILL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOME_PERIOD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HIGHEST_NOTE  = 3'd5;

	// One entry of the drive table
	typedef struct packed {
		logic [NOTE_W-1:0] note;
		logic [PER_W-1:0]  period;
		logic [ACC_W-1:0]  accum;
		logic [POS_W-1:0]  position;
		logic              direction;
		logic              still;
	} drive_t;

	localparam int ENTRY_W = $bits(drive_t);

	typedef struct packed {
		logic [INC_W-1:0]  step_inc;
		logic [POS_W-1:0]  max_pos;
		logic [POS_W-1:0]  max_pos_still;
		logic [POS_W-1:0]  min_pos_still;
		logic [PER_W-1:0]  home_period;
		logic [NOTE_W-1:0] highest_note;
	} cfg_t;

	// Command context held for the duration of one table walk
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic              any;
		logic              found;
		logic [NOTE_W-1:0] note;
		logic [PER_W-1:0]  period;
		logic              still;
	} cmd_ctx_t;

endpackage

// ===== rtl/mdst_ram.sv =====
module mdst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/mdst_cfg_regs.sv =====
module mdst_cfg_regs
	import mdst_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_inc      <= INC_W'(80);
			cfg_q.max_pos       <= POS_W'(158);
			cfg_q.max_pos_still <= POS_W'(20);
			cfg_q.min_pos_still <= POS_W'(18);
			cfg_q.home_period   <= PER_W'(2000);
			cfg_q.highest_note  <= NOTE_W'(127);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_INC:      cfg_q.step_inc      <= cfg_data[INC_W-1:0];
				REG_MAX_POS:       cfg_q.max_pos       <= cfg_data[POS_W-1:0];
				REG_MAX_POS_STILL: cfg_q.max_pos_still <= cfg_data[POS_W-1:0];
				REG_MIN_POS_STILL: cfg_q.min_pos_still <= cfg_data[POS_W-1:0];
				REG_HOME_PERIOD:   cfg_q.home_period   <= cfg_data[PER_W-1:0];
				REG_HIGHEST_NOTE:  cfg_q.highest_note  <= cfg_data[NOTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/mdst_drive_upd.sv =====
module mdst_drive_upd
	import mdst_pkg::*;
(
	input  cfg_t             cfg,
	input  cmd_ctx_t         ctx,
	input  drive_t           ent,
	input  logic [ACC_W-1:0] sum,
	output drive_t           nxt,
	output logic             take
);

	logic [ACC_W-1:0] per_x;
	logic [POS_W-1:0] hi;
	logic [POS_W-1:0] lo;

	assign per_x = {1'b0, ent.period};
	assign hi    = ent.still ? cfg.max_pos_still : cfg.max_pos;
	assign lo    = ent.still ? cfg.min_pos_still : '0;

	always_comb begin
		nxt  = ent;
		take = 1'b0;
		case (ctx.op)
			OP_TICK: begin
				if (ent.period != '0) begin
					nxt.accum = sum;
					if (sum > per_x) begin
						nxt.accum = sum - per_x;
						// reverse at the bounds, then step
						if (ent.position >= hi) begin
							nxt.direction = 1'b1;
						end else if (ent.position <= lo) begin
							nxt.direction = 1'b0;
						end
						if (nxt.direction) begin
							nxt.position = ent.position - POS_W'(1);
						end else begin
							nxt.position = ent.position + POS_W'(1);
						end
					end
					// homing drive parks at zero
					if (ent.note == '0 && nxt.position == '0) begin
						nxt.period = '0;
					end
				end else begin
					nxt.accum = '0;
				end
			end
			OP_NOTE_ON: begin
				if (!ctx.any || (ent.period == '0 && !ctx.found)) begin
					nxt.note   = ctx.note;
					nxt.period = ctx.period;
					take       = ctx.any;
				end
			end
			OP_NOTE_OFF: begin
				if (ent.note == ctx.note) begin
					nxt.note   = '0;
					nxt.period = '0;
				end
			end
			OP_SET_PERIOD: nxt.period = ctx.period;
			OP_HOME: begin
				nxt.still    = 1'b0;
				nxt.note     = '0;
				nxt.position = cfg.max_pos;
				nxt.period   = cfg.home_period;
			end
			OP_HALT: begin
				nxt.note   = '0;
				nxt.period = '0;
			end
			OP_SET_MOVE: nxt.still = ctx.still;
			default: ;
		endcase
	end

endmodule

// ===== rtl/multi_drive_step_tone_generator.sv =====
// Channel  Direction  Handshake             Payload
// cmd      in         cmd_valid/cmd_stall   operation, drive_address, note_number,
//                                           note_period, hold_still
// res      out        res_valid/res_stall   step_dir_bits
// cfg      in         cfg_we (no wait)      cfg_index, cfg_data
//
// A tick walks the whole drive table, one table read issued per cycle through
// two pipeline stages, and then passes through the emit state. A command on a
// single drive reads and writes back one entry; a command with nothing to do is
// accepted without leaving idle. The single-port read of the drive memory sets the pace.
// Reset clears the per-entry valid bits at once; no clearing pass is needed.
// A held result (res_stall high) does not block the next command transaction;
// only a later changed tick waits in the emit state for the output register.
module multi_drive_step_tone_generator
	import mdst_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// command channel
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  logic [OP_W-1:0]      operation,
	input  logic [ADDR_W-1:0]    drive_address,
	input  logic [NOTE_W-1:0]    note_number,
	input  logic [PER_W-1:0]     note_period,
	input  logic                 hold_still,
	// result channel
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [OUT_W-1:0]     step_dir_bits,
	// configuration port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	cfg_t cfg;

	mdst_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Sequencer and walk state
	logic [1:0]       state_q;
	logic             rd_act_q;
	logic [DRV_W-1:0] rd_idx_q;
	logic [DRV_W-1:0] rd_end_q;
	logic             s1_vld_s1;
	logic             s1_last_s1;
	logic             s1_evld_s1;
	logic [DRV_W-1:0] s1_idx_s1;
	logic             s2_vld_s2;
	logic             s2_last_s2;
	logic [DRV_W-1:0] s2_idx_s2;
	drive_t           s2_ent_s2;
	logic [ACC_W-1:0] s2_sum_s2;
	cmd_ctx_t         ctx_q;
	logic [DRIVES-1:0] vld_q;
	logic [OUT_W-1:0] bits_q;
	logic [OUT_W-1:0] last_q;
	logic             res_valid_q;
	logic [OUT_W-1:0] res_bits_q;

	// Command decode
	logic             cmd_acc;
	logic [5:0]       addr_x;
	logic             addr_ok;
	logic [DRV_W-1:0] addr_idx;
	logic             all_sel;
	logic             one_sel;
	logic             note_ok;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign addr_x    = 6'(drive_address);
	assign addr_ok   = (addr_x != 6'd0) && (addr_x <= 6'(DRIVES));
	assign addr_idx  = DRV_W'(addr_x - 6'd1);
	assign note_ok   = (operation != OP_NOTE_ON) || (note_number <= cfg.highest_note);

	always_comb begin
		all_sel = 1'b0;
		one_sel = 1'b0;
		case (operation) inside
			OP_TICK, OP_HALT: all_sel = 1'b1;
			OP_NOTE_ON, OP_NOTE_OFF, OP_HOME: begin
				all_sel = (drive_address == '0) && note_ok;
				one_sel = addr_ok && note_ok;
			end
			OP_SET_PERIOD, OP_SET_MOVE: one_sel = addr_ok;
			default: ;
		endcase
	end

	// Drive table memory
	logic [ENTRY_W-1:0] rdata;
	drive_t             s1_ent;
	logic [ACC_W-1:0]   s1_sum;
	drive_t             upd;
	logic               take;
	logic               wr_en;
	logic               rd_en;

	assign rd_en = rd_act_q;
	assign wr_en = s2_vld_s2;

	mdst_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DRIVES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (s2_idx_s2),
		.wdata (upd),
		.re    (rd_en),
		.raddr (rd_idx_q),
		.rdata (rdata)
	);

	// Entry never written since reset reads as zero
	assign s1_ent = s1_evld_s1 ? drive_t'(rdata) : '0;
	assign s1_sum = s1_ent.accum + ACC_W'(cfg.step_inc);

	mdst_drive_upd u_upd (
		.cfg  (cfg),
		.ctx  (ctx_q),
		.ent  (s2_ent_s2),
		.sum  (s2_sum_s2),
		.nxt  (upd),
		.take (take)
	);

	// Packed step/direction word, merged in drive by drive
	logic [OUT_W-1:0] bits_nxt;

	always_comb begin
		bits_nxt = bits_q;
		for (int k = 0; k < OUT_DRIVES; k++) begin
			if (s2_idx_s2 == DRV_W'(k)) begin
				bits_nxt[2*k]   = upd.position[0];
				bits_nxt[2*k+1] = upd.direction;
			end
		end
	end

	logic res_load;
	assign res_load = (state_q == ST_EMIT) && (bits_q != last_q) &&
		(!res_valid_q || !res_stall);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_act_q    <= 1'b0;
			rd_idx_q    <= '0;
			rd_end_q    <= '0;
			s1_vld_s1   <= 1'b0;
			s1_last_s1  <= 1'b0;
			s1_evld_s1  <= 1'b0;
			s1_idx_s1   <= '0;
			s2_vld_s2   <= 1'b0;
			s2_last_s2  <= 1'b0;
			s2_idx_s2   <= '0;
			vld_q       <= '0;
			last_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// read issue
			s1_vld_s1 <= rd_act_q;
			if (rd_act_q) begin
				s1_idx_s1  <= rd_idx_q;
				s1_last_s1 <= (rd_idx_q == rd_end_q);
				s1_evld_s1 <= vld_q[rd_idx_q];
				if (rd_idx_q == rd_end_q) begin
					rd_act_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + DRV_W'(1);
				end
			end
			// data stage
			s2_vld_s2 <= s1_vld_s1;
			if (s1_vld_s1) begin
				s2_idx_s2  <= s1_idx_s1;
				s2_last_s2 <= s1_last_s1;
			end
			// write-back
			if (s2_vld_s2) begin
				vld_q[s2_idx_s2] <= 1'b1;
			end

			// output register: load wins over the drain of the old result
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_acc && (all_sel || one_sel)) begin
						state_q  <= ST_RUN;
						rd_act_q <= 1'b1;
						rd_idx_q <= all_sel ? '0 : addr_idx;
						rd_end_q <= all_sel ? DRV_W'(DRIVES - 1) : addr_idx;
					end
				end
				ST_RUN: begin
					if (s2_vld_s2 && s2_last_s2) begin
						state_q <= (ctx_q.op == OP_TICK) ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (bits_q == last_q) begin
						state_q <= ST_IDLE;
					end else if (res_load) begin
						last_q  <= bits_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (s1_vld_s1) begin
			s2_ent_s2 <= s1_ent;
			s2_sum_s2 <= s1_sum;
		end
		if (cmd_acc) begin
			ctx_q.op     <= operation;
			ctx_q.any    <= all_sel;
			ctx_q.found  <= 1'b0;
			ctx_q.note   <= note_number;
			ctx_q.period <= note_period;
			ctx_q.still  <= hold_still;
			bits_q       <= '0;
		end else if (s2_vld_s2) begin
			bits_q <= bits_nxt;
			if (take) begin
				ctx_q.found <= 1'b1;
			end
		end
		if (res_load) begin
			res_bits_q <= bits_q;
		end
	end

	assign res_valid     = res_valid_q;
	assign step_dir_bits = res_bits_q;

endmodule

// ===== rtl/mdst_checker.sv =====
module mdst_checker
	import mdst_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_stall,
	input logic [OP_W-1:0]   operation,
	input logic              res_valid,
	input logic              res_stall,
	input logic [OUT_W-1:0]  step_dir_bits
);

	logic cmd_acc;
	assign cmd_acc = cmd_valid && !cmd_stall;

	// held result keeps its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(step_dir_bits))
		else $error("result changed while stalled");

	// a tick always walks the table
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && operation == OP_TICK |=> cmd_stall)
		else $error("tick did not occupy the block");

	// no result appears right after a command transaction
	a_no_early_res: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> !$rose(res_valid))
		else $error("result too early after command");

	// a new result only comes out of a busy period
	a_res_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_stall))
		else $error("result without a walk");

	// reset state, seen on the next edge after reset is sampled
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !res_valid && !cmd_stall)
		else $error("outputs not idle in reset");

endmodule

bind multi_drive_step_tone_generator mdst_checker u_mdst_checker (.*);
